/* design/odi16_pkg.sv */
// Package: widths, dither mask ROM and lookup for the IRGB ordered dither unit.
package odi16_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned NUM_CHAN = 3;
  localparam int unsigned DIV_W    = CHAN_W + 1;   // max + 8 reaches 263
  localparam int unsigned SPREAD_W = CHAN_W + 2;   // 3 * max reaches 765
  localparam int unsigned MASK_W   = 32;
  localparam int unsigned POS_W    = 5;

  localparam logic [DIV_W-1:0]    DIVISOR_BIAS = DIV_W'(8);
  localparam logic [SPREAD_W-1:0] GREY_LIMIT   = SPREAD_W'(8);
  localparam logic [MASK_W-1:0]   FULL_MASK    = 32'hFFFF_FFFF;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [IDX_W-1:0]   nib_t;
  typedef logic [MASK_W-1:0]  mask_t;

  // Ordered dither masks, one 4x4 tile per entry, row n in byte n.
  localparam mask_t DITHER_ROM [16] = '{
    32'h0000_0000, 32'h8800_0000, 32'h8800_2200, 32'h8800_AA00,
    32'hAA00_AA00, 32'hAA44_AA00, 32'hAA44_AA11, 32'hAA44_AA55,
    32'hAA55_AA55, 32'hAADD_AA55, 32'hAADD_AA77, 32'hAADD_AAFF,
    32'hAAFF_AAFF, 32'hEEFF_AAFF, 32'hEEFF_BBFF, 32'hEEFF_FFFF
  };

  // The bright table differs from the dim table only in its top entry.
  function automatic mask_t dith_mask(input nib_t idx, input logic bright_tab);
    mask_t m;
    m = DITHER_ROM[idx];
    if (bright_tab && (idx == nib_t'(15))) begin
      m = FULL_MASK;
    end
    return m;
  endfunction

endpackage

/* design/odi16_if.sv */
// Interfaces: pixel input channel and palette index output channel.
interface odi16_pix_if;
  logic                 valid;
  logic                 ready;
  odi16_pkg::chan_t     red;
  odi16_pkg::chan_t     green;
  odi16_pkg::chan_t     blue;
  odi16_pkg::phase_t    col_phase;
  odi16_pkg::phase_t    row_phase;

  modport source (output valid, red, green, blue, col_phase, row_phase, input ready);
  modport sink   (input valid, red, green, blue, col_phase, row_phase, output ready);
endinterface

interface odi16_idx_if;
  logic              valid;
  logic              ready;
  odi16_pkg::nib_t   palette_index;

  modport source (output valid, palette_index, input ready);
  modport sink   (input valid, palette_index, output ready);
endinterface

/* design/ordered_dither_irgb16_unit.sv */
// Top level: four-stage pipelined 4x4 ordered dither to a 16-color IRGB palette.
//
//   channel  | dir | payload                                   | handshake
//   pix_i    | in  | red, green, blue, col_phase, row_phase    | valid / ready
//   idx_o    | out | palette_index (bit0 R, 1 G, 2 B, 3 I)     | valid / ready
//
// One pixel transfer per clock while idx_o does not stall; output valid rises once a pixel
// has moved through the stage 1, stage 2 and stage 3 registers into the output register.
// Stages: max and divisor, two division steps plus class, two division steps, mask lookup.
// The per-channel division c*16/(max+8) is a restoring divider, two quotient bits per stage.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stall on idx_o holds each full stage; empty stages still fill, so bubbles close up.
module ordered_dither_irgb16_unit (
  input logic         clk_i,
  input logic         rst_ni,
  odi16_pix_if.sink   pix_i,
  odi16_idx_if.source idx_o
);
  import odi16_pkg::*;

  // Stage valid bits and advance enables
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic adv1, adv2, adv3, adv4;

  // Stage 1 payload
  chan_t              s1_chan_q [NUM_CHAN];
  chan_t              s1_max_q;
  logic [DIV_W-1:0]   s1_div_q;
  phase_t             s1_col_q, s1_row_q;
  chan_t              max_d;
  logic [DIV_W-1:0]   div_d;

  // Stage 2 payload
  logic [DIV_W-1:0]   s2_rem_q [NUM_CHAN];
  logic [1:0]         s2_quo_q [NUM_CHAN];
  nib_t               s2_dim_q [NUM_CHAN];
  logic [DIV_W-1:0]   s2_div_q;
  logic               s2_bright_q, s2_grey_q, s2_mid_q;
  nib_t               s2_mi_q;
  phase_t             s2_col_q, s2_row_q;
  logic [DIV_W-1:0]   rem2_d [NUM_CHAN];
  logic [1:0]         quo2_d [NUM_CHAN];
  logic               grey_d;

  // Stage 3 payload
  nib_t               s3_quo_q [NUM_CHAN];
  nib_t               s3_dim_q [NUM_CHAN];
  logic               s3_bright_q, s3_grey_q, s3_mid_q;
  nib_t               s3_mi_q;
  phase_t             s3_col_q, s3_row_q;
  nib_t               quo3_d [NUM_CHAN];

  // Output register
  nib_t               out_idx_q;
  nib_t               out_idx_d;

  // Advance a stage when it is empty or its successor advances
  assign adv4 = !out_v_q || idx_o.ready;
  assign adv3 = !s3_v_q  || adv4;
  assign adv2 = !s2_v_q  || adv3;
  assign adv1 = !s1_v_q  || adv2;

  assign pix_i.ready         = adv1;
  assign idx_o.valid         = out_v_q;
  assign idx_o.palette_index = out_idx_q;

  // Move valid bits down the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv1) s1_v_q  <= pix_i.valid;
      if (adv2) s2_v_q  <= s1_v_q;
      if (adv3) s3_v_q  <= s2_v_q;
      if (adv4) out_v_q <= s3_v_q;
    end
  end

  // Stage 1: largest channel and divisor max + 8
  always_comb begin
    max_d = (pix_i.red > pix_i.green) ? pix_i.red : pix_i.green;
    if (max_d < pix_i.blue) begin
      max_d = pix_i.blue;
    end
    div_d = {1'b0, max_d} + DIVISOR_BIAS;
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_chan_q[0] <= pix_i.red;
      s1_chan_q[1] <= pix_i.green;
      s1_chan_q[2] <= pix_i.blue;
      s1_max_q     <= max_d;
      s1_div_q     <= div_d;
      s1_col_q     <= pix_i.col_phase;
      s1_row_q     <= pix_i.row_phase;
    end
  end

  // Stage 2: first two quotient bits and the grey test
  always_comb begin
    logic [DIV_W:0]     t;
    logic [DIV_W-1:0]   r;
    logic [SPREAD_W-1:0] spread;
    for (int i = 0; i < NUM_CHAN; i++) begin
      r = {1'b0, s1_chan_q[i]};
      for (int s = 1; s >= 0; s--) begin
        t = {r, 1'b0};
        if (t >= {1'b0, s1_div_q}) begin
          quo2_d[i][s] = 1'b1;
          t            = t - {1'b0, s1_div_q};
        end else begin
          quo2_d[i][s] = 1'b0;
        end
        r = t[DIV_W-1:0];
      end
      rem2_d[i] = r;
    end
    spread = SPREAD_W'(3) * {2'b00, s1_max_q}
           - {2'b00, s1_chan_q[0]} - {2'b00, s1_chan_q[1]} - {2'b00, s1_chan_q[2]};
    grey_d = (spread < GREY_LIMIT);
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        s2_rem_q[i] <= rem2_d[i];
        s2_quo_q[i] <= quo2_d[i];
        s2_dim_q[i] <= s1_chan_q[i][6:3];
      end
      s2_div_q    <= s1_div_q;
      s2_bright_q <= s1_max_q[7];
      s2_grey_q   <= grey_d;
      s2_mid_q    <= s1_max_q[6];
      s2_mi_q     <= s1_max_q[7] ? s1_max_q[6:3] : s1_max_q[5:2];
      s2_col_q    <= s1_col_q;
      s2_row_q    <= s1_row_q;
    end
  end

  // Stage 3: last two quotient bits
  always_comb begin
    logic [DIV_W:0]   t;
    logic [DIV_W-1:0] r;
    for (int i = 0; i < NUM_CHAN; i++) begin
      r = s2_rem_q[i];
      quo3_d[i][3:2] = s2_quo_q[i];
      for (int s = 1; s >= 0; s--) begin
        t = {r, 1'b0};
        if (t >= {1'b0, s2_div_q}) begin
          quo3_d[i][s] = 1'b1;
          t            = t - {1'b0, s2_div_q};
        end else begin
          quo3_d[i][s] = 1'b0;
        end
        r = t[DIV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        s3_quo_q[i] <= quo3_d[i];
        s3_dim_q[i] <= s2_dim_q[i];
      end
      s3_bright_q <= s2_bright_q;
      s3_grey_q   <= s2_grey_q;
      s3_mid_q    <= s2_mid_q;
      s3_mi_q     <= s2_mi_q;
      s3_col_q    <= s2_col_q;
      s3_row_q    <= s2_row_q;
    end
  end

  // Stage 4: pick masks by class and take the tile bit
  always_comb begin
    logic [POS_W-1:0] pos;
    mask_t            chm;
    mask_t            mim;
    pos = {s3_row_q, 1'b0, s3_col_q};
    for (int i = 0; i < NUM_CHAN; i++) begin
      if (s3_bright_q) begin
        chm = dith_mask(s3_quo_q[i], 1'b1);
      end else if (s3_grey_q) begin
        chm = s3_mid_q ? dith_mask(s3_mi_q, 1'b0) : '0;
      end else begin
        chm = dith_mask(s3_dim_q[i], 1'b0);
      end
      out_idx_d[i] = chm[pos];
    end
    if (s3_bright_q) begin
      mim = dith_mask(s3_mi_q, 1'b1);
    end else if (s3_grey_q) begin
      mim = s3_mid_q ? ~dith_mask(s3_mi_q, 1'b0) : dith_mask(s3_mi_q, 1'b0);
    end else begin
      mim = '0;
    end
    out_idx_d[3] = mim[pos];
  end

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      out_idx_q <= out_idx_d;
    end
  end

`ifndef SYNTHESIS
  // Stage 1 holds the true maximum and its divisor
  a_max_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> (s1_max_q >= s1_chan_q[0]) && (s1_max_q >= s1_chan_q[1])
            && (s1_max_q >= s1_chan_q[2]) && (s1_div_q == {1'b0, s1_max_q} + DIVISOR_BIAS))
    else $error("stage 1 max or divisor wrong");

  // Partial remainders stay below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (s2_rem_q[0] < s2_div_q) && (s2_rem_q[1] < s2_div_q)
            && (s2_rem_q[2] < s2_div_q))
    else $error("division remainder out of range");

  // A stalled stage 3 keeps its item
  a_s3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q && !adv3 |=> s3_v_q && $stable(s3_quo_q[0]) && $stable(s3_mi_q)
                        && $stable(s3_col_q) && $stable(s3_row_q))
    else $error("stage 3 item changed during stall");

  // A new result only appears from a full stage 3
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(s3_v_q))
    else $error("output valid without a stage 3 item");
`endif

endmodule

/* tb/sv/ordered_dither_irgb16_unit_tb.sv */
// Testbench: directed and random pixel streams through the IRGB ordered dither unit.
module ordered_dither_irgb16_unit_tb;
  import odi16_pkg::*;

  localparam int unsigned CLK_HALF    = 10;
  localparam int unsigned RST_CYCLES  = 11;
  localparam int unsigned RAND_PIXELS = 1100;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned NUM_ROWS    = 20;

  // One pixel of stimulus; fixed rows carry a hand-worked palette index.
  typedef struct packed {
    chan_t  red;
    chan_t  green;
    chan_t  blue;
    phase_t col_phase;
    phase_t row_phase;
    logic   fixed;
    nib_t   want;
  } pixel_t;

  // Dither tiles, row n in byte n; the bright set saturates its top entry.
  localparam logic [31:0] DIM_TILE [16] = '{
    32'h00000000, 32'h88000000, 32'h88002200, 32'h8800AA00,
    32'hAA00AA00, 32'hAA44AA00, 32'hAA44AA11, 32'hAA44AA55,
    32'hAA55AA55, 32'hAADDAA55, 32'hAADDAA77, 32'hAADDAAFF,
    32'hAAFFAAFF, 32'hEEFFAAFF, 32'hEEFFBBFF, 32'hEEFFFFFF
  };
  localparam logic [31:0] BRIGHT_TILE [16] = '{
    32'h00000000, 32'h88000000, 32'h88002200, 32'h8800AA00,
    32'hAA00AA00, 32'hAA44AA00, 32'hAA44AA11, 32'hAA44AA55,
    32'hAA55AA55, 32'hAADDAA55, 32'hAADDAA77, 32'hAADDAAFF,
    32'hAAFFAAFF, 32'hEEFFAAFF, 32'hEEFFBBFF, 32'hFFFFFFFF
  };

  // Directed pixels: red, green, blue, col, row, fixed, palette index.
  localparam pixel_t DIRECTED [NUM_ROWS] = '{
    // black is dark grey with empty masks
    '{8'd0,   8'd0,   8'd0,   2'd0, 2'd0, 1'b1, 4'd0},
    '{8'd0,   8'd0,   8'd0,   2'd3, 2'd3, 1'b1, 4'd0},
    // white fills every mask
    '{8'd255, 8'd255, 8'd255, 2'd0, 2'd0, 1'b1, 4'd15},
    '{8'd255, 8'd255, 8'd255, 2'd3, 2'd3, 1'b1, 4'd15},
    // full-scale primaries: own channel and bright full, others empty
    '{8'd255, 8'd0,   8'd0,   2'd1, 2'd2, 1'b1, 4'd9},
    '{8'd0,   8'd255, 8'd0,   2'd2, 2'd1, 1'b1, 4'd10},
    '{8'd0,   8'd0,   8'd255, 2'd3, 2'd0, 1'b1, 4'd12},
    // bright threshold, where the bright mask index wraps to zero
    '{8'd128, 8'd128, 8'd128, 2'd1, 2'd1, 1'b0, 4'd0},
    '{8'd128, 8'd0,   8'd0,   2'd3, 2'd3, 1'b0, 4'd0},
    // top of mid grey
    '{8'd127, 8'd127, 8'd127, 2'd0, 2'd3, 1'b0, 4'd0},
    // bottom of mid grey: bright mask is the inverse of an empty tile
    '{8'd64,  8'd64,  8'd64,  2'd2, 2'd2, 1'b1, 4'd8},
    // top of dark grey
    '{8'd63,  8'd63,  8'd63,  2'd3, 2'd3, 1'b0, 4'd0},
    // spread of seven stays grey, spread of eight turns dim colour
    '{8'd63,  8'd60,  8'd59,  2'd1, 2'd3, 1'b0, 4'd0},
    '{8'd63,  8'd60,  8'd58,  2'd1, 2'd3, 1'b0, 4'd0},
    // dim colour
    '{8'd127, 8'd0,   8'd0,   2'd0, 2'd3, 1'b0, 4'd0},
    '{8'd100, 8'd20,  8'd50,  2'd2, 2'd0, 1'b0, 4'd0},
    '{8'd0,   8'd0,   8'd8,   2'd3, 2'd3, 1'b0, 4'd0},
    // bright mixed colours
    '{8'd200, 8'd100, 8'd30,  2'd1, 2'd1, 1'b0, 4'd0},
    '{8'd136, 8'd136, 8'd0,   2'd0, 2'd2, 1'b0, 4'd0},
    '{8'd255, 8'd254, 8'd1,   2'd2, 2'd3, 1'b0, 4'd0}
  };

  logic clk_i;
  logic rst_ni;

  odi16_pix_if pix_if ();
  odi16_idx_if idx_if ();

  ordered_dither_irgb16_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .idx_o  (idx_if)
  );

  pixel_t      cur_px;
  nib_t        index_q [$];
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  logic        sink_hold_req;

  // Work out the palette index for one pixel from class, tile and phase.
  function automatic nib_t predict_index(input pixel_t px);
    int unsigned r, g, b, top, spread, k;
    logic [4:0]  pos;
    logic [31:0] mr, mg, mb, mi;
    r = px.red;
    g = px.green;
    b = px.blue;
    top = (r > g) ? r : g;
    if (b > top) top = b;
    if (top > 127) begin
      mi = BRIGHT_TILE[4'((top >> 3) & 15)];
      mr = BRIGHT_TILE[4'((r * 16) / (top + 8))];
      mg = BRIGHT_TILE[4'((g * 16) / (top + 8))];
      mb = BRIGHT_TILE[4'((b * 16) / (top + 8))];
    end else begin
      spread = 3 * top - r - g - b;
      if (spread < 8) begin
        if (top > 63) begin
          k  = (top - 64) >> 2;
          mi = ~DIM_TILE[4'(k)];
          mr = DIM_TILE[4'(k)];
        end else begin
          mi = DIM_TILE[4'(top >> 2)];
          mr = '0;
        end
        mg = mr;
        mb = mr;
      end else begin
        mi = '0;
        mr = DIM_TILE[4'(r >> 3)];
        mg = DIM_TILE[4'(g >> 3)];
        mb = DIM_TILE[4'(b >> 3)];
      end
    end
    pos = 5'(8 * px.row_phase + px.col_phase);
    return {mi[pos], mb[pos], mg[pos], mr[pos]};
  endfunction

  // Draw a random pixel, steered toward each class and its borders.
  function automatic pixel_t random_pixel();
    pixel_t px;
    int unsigned mode, base;
    px   = '0;
    mode = $urandom_range(0, 9);
    if (mode < 3) begin
      px.red   = chan_t'($urandom_range(0, 255));
      px.green = chan_t'($urandom_range(0, 255));
      px.blue  = chan_t'($urandom_range(0, 255));
    end else if (mode < 5) begin
      // near-grey, spread kept below the grey limit
      base     = $urandom_range(0, 127);
      px.red   = chan_t'(base - ((base < 3) ? base : $urandom_range(0, 3)));
      px.green = chan_t'(base - ((base < 3) ? base : $urandom_range(0, 3)));
      px.blue  = chan_t'(base - ((base < 3) ? base : $urandom_range(0, 3)));
    end else if (mode < 7) begin
      px.red   = chan_t'($urandom_range(0, 127));
      px.green = chan_t'($urandom_range(0, 127));
      px.blue  = chan_t'($urandom_range(0, 127));
    end else begin
      px.red   = chan_t'($urandom_range(0, 255));
      px.green = chan_t'($urandom_range(0, 255));
      px.blue  = chan_t'($urandom_range(0, 255));
      case ($urandom_range(0, 2))
        0: px.red[CHAN_W-1] = 1'b1;
        1: px.green[CHAN_W-1] = 1'b1;
        default: px.blue[CHAN_W-1] = 1'b1;
      endcase
    end
    px.col_phase = phase_t'($urandom_range(0, 3));
    px.row_phase = phase_t'($urandom_range(0, 3));
    return px;
  endfunction

  // Offer one pixel in bursts with random gaps and hold it until the transfer.
  task automatic send_pixel(input pixel_t px);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    cur_px           <= px;
    pix_if.valid     <= 1'b1;
    pix_if.red       <= px.red;
    pix_if.green     <= px.green;
    pix_if.blue      <= px.blue;
    pix_if.col_phase <= px.col_phase;
    pix_if.row_phase <= px.row_phase;
    do @(posedge clk_i); while (!pix_if.ready);
  endtask

  // Drop valid and wait until every expected index has come back.
  task automatic drain_pipe();
    pix_if.valid <= 1'b0;
    do @(posedge clk_i); while (index_q.size() != 0);
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ordered_dither_irgb16_unit regression: fail");
      $finish;
    end
  end

  // Record expectations on input transfers, check output transfers
  always @(posedge clk_i) begin
    nib_t want;
    if (rst_ni) begin
      if (idx_if.valid && idx_if.ready) begin
        if (index_q.size() == 0) begin
          $error("palette_index: unexpected result, expected none, actual %0d",
                 idx_if.palette_index);
          err_count++;
        end else begin
          want = index_q.pop_front();
          if (idx_if.palette_index !== want) begin
            $error("palette_index: expected %0d, actual %0d", want, idx_if.palette_index);
            err_count++;
          end
        end
      end
      if (pix_if.valid && pix_if.ready) begin
        index_q.push_back(cur_px.fixed ? cur_px.want : predict_index(cur_px));
      end
    end
  end

  // Receiver: stretches of steady, random and sparse ready, plus one long hold
  initial begin
    int unsigned mode, len;
    logic        hold_done;
    hold_done = 1'b0;
    idx_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (sink_hold_req && !hold_done) begin
        hold_done = 1'b1;
        idx_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(1, 60);
        repeat (len) begin
          case (mode)
            0: idx_if.ready <= 1'b1;
            1: idx_if.ready <= 1'($urandom_range(0, 1));
            default: idx_if.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Stimulus
  initial begin
    burst_left       = 0;
    sink_hold_req    = 1'b0;
    cur_px           = '0;
    rst_ni           <= 1'b0;
    pix_if.valid     <= 1'b0;
    pix_if.red       <= '0;
    pix_if.green     <= '0;
    pix_if.blue      <= '0;
    pix_if.col_phase <= '0;
    pix_if.row_phase <= '0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pixels, then pause until the pipe is empty
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_pixel(DIRECTED[i]);
    end
    drain_pipe();

    // random pixels; hold the receiver off early so the pipe fills and stalls
    sink_hold_req = 1'b1;
    for (int i = 0; i < RAND_PIXELS; i++) begin
      if (i == RAND_PIXELS / 2) drain_pipe();
      send_pixel(random_pixel());
    end
    drain_pipe();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("ordered_dither_irgb16_unit regression: pass");
    end else begin
      $display("ordered_dither_irgb16_unit regression: fail");
    end
    $finish;
  end

endmodule
